FILE: sv/lvsf_pkg.sv
// Shared types, widths and codes for the velocity state-feedback core.
`default_nettype none
package lvsf_pkg;

    // Data format: signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction bits
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Exact accumulator: position error product is 2*DATA_WIDTH+1 bits, four terms
    // add two more, negation one more
    localparam int ACC_W = 2 * DATA_WIDTH + 4;

    // Rounding constant: half an LSB of the result
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    // Configuration bus
    localparam int NUM_REGS = 6;
    localparam int APB_DW   = 32;
    localparam int ADDR_W   = $clog2(NUM_REGS) + 2;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic        [DATA_WIDTH-2:0] t_limit;

    // Item kinds
    typedef enum logic [0:0] {
        CMD_MEAS = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    // Register indexes (word address)
    typedef enum logic [ADDR_W-3:0] {
        REG_GOAL_POSITION      = 3'd0,
        REG_GAIN_POSITION      = 3'd1,
        REG_GAIN_VELOCITY      = 3'd2,
        REG_GAIN_PREV_VELOCITY = 3'd3,
        REG_GAIN_PREV_COMMAND  = 3'd4,
        REG_MAX_SPEED          = 3'd5
    } t_reg_idx;

    // Reset values
    localparam t_data  GOAL_RESET  = t_data'(327680);
    localparam t_limit SPEED_RESET = t_limit'(196608);

    typedef struct packed {
        t_cmd  cmd;
        t_data position;
        t_data velocity;
    } t_in_item;

    typedef struct packed {
        t_data velocity_command;
        logic  measurement_seen;
    } t_out_item;

    typedef struct packed {
        t_data  goal_position;
        t_data  gain_position;
        t_data  gain_velocity;
        t_data  gain_prev_velocity;
        t_data  gain_prev_command;
        t_limit max_speed;
    } t_cfg;

endpackage
`default_nettype wire

FILE: sv/lqr_velocity_state_feedback_core.sv
// Top level: input register, feedback state, control law and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries two item kinds.
//   A measurement item (cmd = CMD_MEAS) stores position and velocity and gives
//   no result. A tick item (cmd = CMD_TICK) gives one velocity command on the
//   output channel (o_out_valid / i_out_stall / o_out_item).
//   Path: an accepted item is held in the input register; when it fires, a tick
//   writes its result into the result register and a measurement into state.
//   Throughput: one item per cycle, back to back, of either kind, while no tick
//   is stalled. The feedback on the previous command is combinational: the
//   four gain multipliers and clamp sit between state and result registers.
//   Stall: while the result register holds an untaken result, a waiting tick
//   stays in the input register and o_in_stall rises; measurements still pass.
//   Reset: clears the valid flags, seen flag and feedback state; registers go
//   to goal 5.0, gains 0, max speed 3.0. Ticks before the first measurement
//   return a zero command with measurement_seen low and leave state unchanged.
//   Users write configuration over the APB port only while idle (not enforced).
`default_nettype none
module lqr_velocity_state_feedback_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire lvsf_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output lvsf_pkg::t_out_item              o_out_item,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lvsf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lvsf_pkg::APB_DW-1:0] pwdata,
    output logic      [lvsf_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import lvsf_pkg::*;

    t_cfg      w_cfg;
    t_data     w_command;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      r_seen;
    t_data     r_pos;
    t_data     r_vel;
    t_data     r_prev_vel;
    t_data     r_prev_cmd;

    logic      w_out_free;
    logic      w_fire;
    logic      w_is_tick;
    logic      w_accept;

    lvsf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lvsf_law u_law (
        .i_cfg           (w_cfg),
        .i_position      (r_pos),
        .i_velocity      (r_vel),
        .i_prev_velocity (r_prev_vel),
        .i_prev_command  (r_prev_cmd),
        .o_command       (w_command)
    );

    // Flow control: a measurement never needs the result register
    assign w_is_tick  = (r_in.cmd == CMD_TICK);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && (!w_is_tick || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Valid flags and seen flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seen      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire && w_is_tick) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire && !w_is_tick) begin
                r_seen <= 1'b1;
            end
        end
    end

    // Feedback state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_vel      <= '0;
            r_prev_vel <= '0;
            r_prev_cmd <= '0;
        end else if (w_fire) begin
            if (!w_is_tick) begin
                r_pos <= r_in.position;
                r_vel <= r_in.velocity;
            end else if (r_seen) begin
                r_prev_vel <= r_vel;
                r_prev_cmd <= w_command;
            end
        end
    end

    // Input and result payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
        if (w_fire && w_is_tick) begin
            r_out.velocity_command <= r_seen ? w_command : '0;
            r_out.measurement_seen <= r_seen;
        end
    end

endmodule
`default_nettype wire

FILE: sv/lvsf_cfg_regs.sv
// APB-style configuration register file for goal, gains and speed limit.
`default_nettype none
module lvsf_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lvsf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lvsf_pkg::APB_DW-1:0] pwdata,
    output logic      [lvsf_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output lvsf_pkg::t_cfg                   o_cfg
);
    import lvsf_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register write decode; unknown indexes are ignored
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_GOAL_POSITION:      n_cfg.goal_position      = t_data'(pwdata);
                REG_GAIN_POSITION:      n_cfg.gain_position      = t_data'(pwdata);
                REG_GAIN_VELOCITY:      n_cfg.gain_velocity      = t_data'(pwdata);
                REG_GAIN_PREV_VELOCITY: n_cfg.gain_prev_velocity = t_data'(pwdata);
                REG_GAIN_PREV_COMMAND:  n_cfg.gain_prev_command  = t_data'(pwdata);
                REG_MAX_SPEED:          n_cfg.max_speed          = pwdata[DATA_WIDTH-2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_position      <= GOAL_RESET;
            r_cfg.gain_position      <= '0;
            r_cfg.gain_velocity      <= '0;
            r_cfg.gain_prev_velocity <= '0;
            r_cfg.gain_prev_command  <= '0;
            r_cfg.max_speed          <= SPEED_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read-back mux
    always_comb begin
        case (w_idx)
            REG_GOAL_POSITION:      prdata = APB_DW'(unsigned'(r_cfg.goal_position));
            REG_GAIN_POSITION:      prdata = APB_DW'(unsigned'(r_cfg.gain_position));
            REG_GAIN_VELOCITY:      prdata = APB_DW'(unsigned'(r_cfg.gain_velocity));
            REG_GAIN_PREV_VELOCITY: prdata = APB_DW'(unsigned'(r_cfg.gain_prev_velocity));
            REG_GAIN_PREV_COMMAND:  prdata = APB_DW'(unsigned'(r_cfg.gain_prev_command));
            REG_MAX_SPEED:          prdata = APB_DW'(r_cfg.max_speed);
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/lvsf_law.sv
// Control law: four parallel products, exact sum, negate, round and clamp.
`default_nettype none
module lvsf_law (
    input  wire lvsf_pkg::t_cfg  i_cfg,
    input  wire lvsf_pkg::t_data i_position,
    input  wire lvsf_pkg::t_data i_velocity,
    input  wire lvsf_pkg::t_data i_prev_velocity,
    input  wire lvsf_pkg::t_data i_prev_command,
    output lvsf_pkg::t_data      o_command
);
    import lvsf_pkg::*;

    logic signed [DATA_WIDTH:0]     w_err;
    logic signed [2*DATA_WIDTH:0]   w_p_pos;
    logic signed [2*DATA_WIDTH-1:0] w_p_vel;
    logic signed [2*DATA_WIDTH-1:0] w_p_pvel;
    logic signed [2*DATA_WIDTH-1:0] w_p_pcmd;
    logic signed [ACC_W-1:0]        w_sum;
    logic signed [ACC_W-1:0]        w_neg;
    logic signed [ACC_W-1:0]        w_rnd;
    logic signed [ACC_W-1:0]        w_shf;
    logic signed [ACC_W-1:0]        w_lim;
    logic signed [ACC_W-1:0]        w_nlim;

    // Exact position error
    assign w_err = (DATA_WIDTH+1)'(i_position) - (DATA_WIDTH+1)'(i_cfg.goal_position);

    // Gain products
    assign w_p_pos  = i_cfg.gain_position      * w_err;
    assign w_p_vel  = i_cfg.gain_velocity      * i_velocity;
    assign w_p_pvel = i_cfg.gain_prev_velocity * i_prev_velocity;
    assign w_p_pcmd = i_cfg.gain_prev_command  * i_prev_command;

    // Sum, negate, round half up, drop fraction bits
    assign w_sum = ACC_W'(w_p_pos) + ACC_W'(w_p_vel) + ACC_W'(w_p_pvel) + ACC_W'(w_p_pcmd);
    assign w_neg = -w_sum;
    assign w_rnd = w_neg + ACC_HALF;
    assign w_shf = w_rnd >>> FRAC_BITS;

    // Symmetric clamp
    assign w_lim  = signed'(ACC_W'(i_cfg.max_speed));
    assign w_nlim = -w_lim;

    always_comb begin
        if (w_shf > w_lim) begin
            o_command = w_lim[DATA_WIDTH-1:0];
        end else if (w_shf < w_nlim) begin
            o_command = w_nlim[DATA_WIDTH-1:0];
        end else begin
            o_command = w_shf[DATA_WIDTH-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the velocity state-feedback core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lvsf_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles with no item moved before giving up
    localparam int SETTLE_TICKS = 3;     // a measurement may still be in flight
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 200;
    localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (FRAC_BITS - 1);

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    lqr_velocity_state_feedback_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // Control-law shadow: registers and feedback state
    t_cfg      law_cfg;
    logic      seen_meas;
    t_data     meas_position;
    t_data     meas_velocity;
    t_data     prior_velocity;
    t_data     prior_command;
    t_out_item command_queue[$];

    int error_count = 0;
    int quiet_cycles = 0;

    // Sender and receiver pacing
    logic tx_calm = 1'b0;
    logic tx_force_calm = 1'b0;
    int   tx_phase_left = 0;
    int   hold_req = 0;
    int   hold_left = 0;
    logic rx_calm = 1'b0;
    int   rx_phase_left = 0;
    int   stall_run = 0;

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic logic signed [127:0] wide_product(input longint a, input longint b);
        logic signed [127:0] x, y;
        x = a;
        y = b;
        return x * y;
    endfunction

    // Apply one accepted item to the shadow; a tick queues its command
    function automatic void control_law_step(input t_in_item it);
        longint              pos_err;
        logic signed [127:0] acc;
        logic signed [127:0] lim;
        t_out_item           res;
        if (it.cmd == CMD_MEAS) begin
            meas_position = it.position;
            meas_velocity = it.velocity;
            seen_meas     = 1'b1;
            return;
        end
        res.measurement_seen = seen_meas;
        res.velocity_command = '0;
        if (seen_meas) begin
            pos_err = longint'(meas_position) - longint'(law_cfg.goal_position);
            acc = wide_product(longint'(law_cfg.gain_position), pos_err)
                + wide_product(longint'(law_cfg.gain_velocity), longint'(meas_velocity))
                + wide_product(longint'(law_cfg.gain_prev_velocity), longint'(prior_velocity))
                + wide_product(longint'(law_cfg.gain_prev_command), longint'(prior_command));
            // negate, round half up, drop the fraction of the product
            acc = (-acc + HALF_LSB) >>> FRAC_BITS;
            lim = '0;
            lim[DATA_WIDTH-2:0] = law_cfg.max_speed;
            if (acc > lim) begin
                acc = lim;
            end else if (acc < -lim) begin
                acc = -lim;
            end
            res.velocity_command = t_data'(acc[DATA_WIDTH-1:0]);
            prior_velocity = meas_velocity;
            prior_command  = res.velocity_command;
        end
        command_queue.push_back(res);
    endfunction

    function automatic logic [APB_DW-1:0] register_image(input t_reg_idx idx);
        case (idx)
            REG_GOAL_POSITION:      return law_cfg.goal_position;
            REG_GAIN_POSITION:      return law_cfg.gain_position;
            REG_GAIN_VELOCITY:      return law_cfg.gain_velocity;
            REG_GAIN_PREV_VELOCITY: return law_cfg.gain_prev_velocity;
            REG_GAIN_PREV_COMMAND:  return law_cfg.gain_prev_command;
            REG_MAX_SPEED:          return {1'b0, law_cfg.max_speed};
            default:                return '0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    // Signed value within +-2^mag_bits, or any 32-bit pattern
    function automatic t_data rand_data(input int mag_bits);
        longint span;
        if (mag_bits >= DATA_WIDTH - 1) return t_data'($urandom);
        span = longint'(1) << mag_bits;
        return t_data'(longint'($urandom_range(0, 32'(2 * span - 1))) - span);
    endfunction

    function automatic t_data meas_value(input int mag_bits);
        return ($urandom_range(0, 99) < 85) ? rand_data(mag_bits) : rand_data(DATA_WIDTH);
    endfunction

    function automatic t_in_item make_item(input t_cmd c, input t_data p, input t_data v);
        t_in_item it;
        it.cmd      = c;
        it.position = p;
        it.velocity = v;
        return it;
    endfunction

    function automatic t_in_item random_tick();
        return make_item(CMD_TICK, rand_data(DATA_WIDTH), rand_data(DATA_WIDTH));
    endfunction

    // Offer one item and hold it until accepted; valid stays high afterwards
    task automatic send_item(input t_in_item it);
        int gap;
        if (tx_phase_left == 0) begin
            tx_calm       = ($urandom_range(0, 3) == 0);
            tx_phase_left = $urandom_range(10, 120);
        end else begin
            tx_phase_left--;
        end
        gap = (tx_calm || tx_force_calm) ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        control_law_step(it);
    endtask

    // Drop valid, drain all commands, let a trailing measurement land
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (command_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GOAL_POSITION:      law_cfg.goal_position      = value[DATA_WIDTH-1:0];
            REG_GAIN_POSITION:      law_cfg.gain_position      = value[DATA_WIDTH-1:0];
            REG_GAIN_VELOCITY:      law_cfg.gain_velocity      = value[DATA_WIDTH-1:0];
            REG_GAIN_PREV_VELOCITY: law_cfg.gain_prev_velocity = value[DATA_WIDTH-1:0];
            REG_GAIN_PREV_COMMAND:  law_cfg.gain_prev_command  = value[DATA_WIDTH-1:0];
            REG_MAX_SPEED:          law_cfg.max_speed          = value[DATA_WIDTH-2:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic read_register(input t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== register_image(idx)) begin
            report_mismatch($sformatf("register %s read %h, want %h",
                                      idx.name(), prdata, register_image(idx)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_registers(input t_data goal, input t_data gp, input t_data gv,
                                       input t_data gvp, input t_data gpc,
                                       input logic [APB_DW-1:0] speed);
        write_register(REG_GOAL_POSITION, goal);
        write_register(REG_GAIN_POSITION, gp);
        write_register(REG_GAIN_VELOCITY, gv);
        write_register(REG_GAIN_PREV_VELOCITY, gvp);
        write_register(REG_GAIN_PREV_COMMAND, gpc);
        write_register(REG_MAX_SPEED, speed);
    endtask

    task automatic check_command(input t_out_item got);
        t_out_item want;
        if (command_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected command %h seen %b",
                                      got.velocity_command, got.measurement_seen));
            return;
        end
        want = command_queue.pop_front();
        if (got.velocity_command !== want.velocity_command) begin
            report_mismatch($sformatf("velocity_command %h, want %h",
                                      got.velocity_command, want.velocity_command));
        end
        if (got.measurement_seen !== want.measurement_seen) begin
            report_mismatch($sformatf("measurement_seen %b, want %b",
                                      got.measurement_seen, want.measurement_seen));
        end
    endtask

    // Result side: check taken commands, then pick next cycle's stall
    always @(posedge i_clk) begin
        logic stall_next;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_command(o_out_item);
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_calm       = ($urandom_range(0, 3) == 0);
                    rx_phase_left = $urandom_range(20, 200);
                end else begin
                    rx_phase_left--;
                end
                if (rx_calm) begin
                    stall_next = 1'b0;
                end else if (stall_run > 0) begin
                    stall_run--;
                    stall_next = 1'b1;
                end else begin
                    stall_run  = pick_gap();
                    stall_next = (stall_run > 0);
                    if (stall_run > 0) stall_run--;
                end
            end
            i_out_stall <= stall_next;
        end
    end

    // Watchdog: no item moved on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic test_register_readback();
        for (int i = 0; i < NUM_REGS; i++) begin
            read_register(t_reg_idx'(i));
        end
    endtask

    // Ticks before any measurement: zero command, flag low, even with gains set
    task automatic test_unmeasured_ticks();
        send_item(random_tick());
        send_item(random_tick());
        wait_idle();
        write_all_registers(GOAL_RESET, 32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_8000,
                            32'sh0000_4000, {1'b0, SPEED_RESET});
        send_item(random_tick());
    endtask

    // Half-LSB ties round toward plus infinity; max speed written with bit 31 set
    task automatic test_rounding_ties();
        wait_idle();
        write_all_registers('0, 32'sd1, '0, '0, '0, 32'hFFFF_FFFF);
        send_item(make_item(CMD_MEAS, 32'sh0000_8000, '0));
        send_item(random_tick());
        send_item(make_item(CMD_MEAS, -32'sh0000_8000, '0));
        send_item(random_tick());
        wait_idle();
        test_register_readback();
    endtask

    // Field and register extremes; sums far beyond the clamp
    task automatic test_extreme_values();
        wait_idle();
        write_all_registers(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 32'sh8000_0000, {1'b0, SPEED_RESET});
        send_item(make_item(CMD_MEAS, 32'sh7FFF_FFFF, 32'sh8000_0000));
        send_item(random_tick());
        send_item(random_tick());
        send_item(make_item(CMD_MEAS, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_item(random_tick());
    endtask

    task automatic test_zero_speed_limit();
        wait_idle();
        write_register(REG_MAX_SPEED, '0);
        send_item(make_item(CMD_MEAS, rand_data(DATA_WIDTH), rand_data(DATA_WIDTH)));
        send_item(random_tick());
    endtask

    // Moderate gains: the law runs without hitting the clamp
    task automatic test_unclamped_law();
        wait_idle();
        write_all_registers(GOAL_RESET, -32'sh0000_8000, 32'sh0001_0000, 32'sh0000_4000,
                            -32'sh0000_2000, 32'h7FFF_FFFF);
        send_item(make_item(CMD_MEAS, rand_data(20), rand_data(18)));
        send_item(random_tick());
        send_item(random_tick());
        send_item(make_item(CMD_MEAS, rand_data(20), rand_data(18)));
        send_item(random_tick());
    endtask

    // Result side holds off while ticks keep coming, so the input backs up
    task automatic test_output_backpressure();
        wait_idle();
        tx_force_calm = 1'b1;
        hold_req = 400;
        repeat (40) begin
            if ($urandom_range(0, 9) < 8) begin
                send_item(random_tick());
            end else begin
                send_item(make_item(CMD_MEAS, meas_value(20), meas_value(18)));
            end
        end
        tx_force_calm = 1'b0;
        wait_idle();
    endtask

    // One register setting, then mostly measurement-then-ticks sequences
    task automatic run_random_phase(input int n_items, input int gain_bits,
                                    input int state_bits, input t_limit speed);
        int sent;
        int r;
        int n_ticks;
        sent = 0;
        wait_idle();
        write_all_registers(rand_data(state_bits), rand_data(gain_bits), rand_data(gain_bits),
                            rand_data(gain_bits), rand_data(gain_bits), {1'b0, speed});
        while (sent < n_items) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                send_item(make_item(CMD_MEAS, meas_value(state_bits), meas_value(state_bits)));
                n_ticks = $urandom_range(1, 3);
                repeat (n_ticks) send_item(random_tick());
                sent += 1 + n_ticks;
            end else if (r == 7) begin
                send_item(random_tick());
                sent += 1;
            end else if (r == 8) begin
                send_item(make_item(CMD_MEAS, meas_value(state_bits), meas_value(state_bits)));
                send_item(make_item(CMD_MEAS, meas_value(state_bits), meas_value(state_bits)));
                sent += 2;
            end else begin
                send_item(make_item(CMD_MEAS, meas_value(state_bits), meas_value(state_bits)));
                sent += 1;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(260, 17, 20, '1);
        run_random_phase(260, 18, 22, t_limit'($urandom_range(0, 1 << 20)));
        run_random_phase(260, DATA_WIDTH, DATA_WIDTH, t_limit'($urandom));
        run_random_phase(260, 16, 18, '1);
        run_random_phase(260, 14, 24, SPEED_RESET);
    endtask

    initial begin
        law_cfg.goal_position      = GOAL_RESET;
        law_cfg.gain_position      = '0;
        law_cfg.gain_velocity      = '0;
        law_cfg.gain_prev_velocity = '0;
        law_cfg.gain_prev_command  = '0;
        law_cfg.max_speed          = SPEED_RESET;
        seen_meas      = 1'b0;
        meas_position  = '0;
        meas_velocity  = '0;
        prior_velocity = '0;
        prior_command  = '0;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_readback();
        test_unmeasured_ticks();
        test_rounding_ties();
        test_extreme_values();
        test_zero_speed_limit();
        test_unclamped_law();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
